>>> rtl/core/ipv4p_pkg.sv
// Shared types, constants and the character classifier for the dotted IPv4 parser.
// No dependencies; every other file of the parser imports this package.
package ipv4p_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // ASCII codes the classifier looks at
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] HEX_UOFS = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] HEX_LOFS = 8'h57;  // 'a' - 10

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_HEXL,
    CC_X,
    CC_DOT,
    CC_NUL,
    CC_SPACE,
    CC_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  val;   // digit or hex-letter value
  } token_t;

  function automatic token_t classify(input logic [CHAR_W-1:0] c);
    token_t t;
    t.cls = CC_OTHER;
    t.val = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t.cls = CC_DIGIT;
      t.val = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      t.cls = CC_HEXL;
      t.val = 4'(c - HEX_LOFS);
    end else if (c >= CH_UA && c <= CH_UF) begin
      t.cls = CC_HEXL;
      t.val = 4'(c - HEX_UOFS);
    end else if (c == CH_LX || c == CH_UX) begin
      t.cls = CC_X;
    end else if (c == CH_DOT) begin
      t.cls = CC_DOT;
    end else if (c == CH_NUL) begin
      t.cls = CC_NUL;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      t.cls = CC_SPACE;
    end
    return t;
  endfunction

endpackage

>>> rtl/core/ipv4p_char_if.sv
// Character request channel: valid/ready handshake carrying one ASCII character.
// Depends on ipv4p_pkg.
interface ipv4p_char_if import ipv4p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

>>> rtl/core/ipv4p_res_if.sv
// Result request channel: valid/ready handshake carrying ok flag and packed address.
// Depends on ipv4p_pkg.
interface ipv4p_res_if import ipv4p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink   (input valid, input ok, input address, output ready);
endinterface

>>> rtl/core/ipv4p_queue.sv
// Short token queue between the classifier front end and the parser back end.
// Depends on ipv4p_pkg (token_t, QUEUE_DEPTH).
module ipv4p_queue import ipv4p_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output token_t pop_data_o,
  output logic   empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  token_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == FULL_CNT);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/ipv4p_front.sv
// Front end: accepts character requests and classifies them into queue tokens.
// Depends on ipv4p_pkg and ipv4p_char_if.
module ipv4p_front import ipv4p_pkg::*; (
  ipv4p_char_if.sink char_i,
  input  logic       full_i,
  output logic       push_o,
  output token_t     token_o
);

  assign char_i.ready = !full_i;
  assign push_o       = char_i.valid && !full_i;
  assign token_o      = classify(char_i.char_in);

endmodule

>>> rtl/core/ipv4p_back.sv
// Back end: per-part accumulation, dot packing, range check and result register.
// Depends on ipv4p_pkg and ipv4p_res_if.
module ipv4p_back import ipv4p_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  token_t       token_i,
  input  logic         empty_i,
  output logic         pop_o,
  ipv4p_res_if.source  res_o
);

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGIT,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_e;

  phase_e            phase_q, phase_d;
  radix_e            radix_q, radix_d;
  logic [ADDR_W-1:0] part_q, part_d;
  logic [ADDR_W-1:0] prefix_q, prefix_d;
  logic [1:0]        parts_q, parts_d;
  logic              out_valid_q;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic              emit;
  logic              out_free;
  logic              do_part;
  radix_e            part_radix;
  logic [ADDR_W-1:0] digit_ext;
  logic [ADDR_W-1:0] acc;
  logic              fits;
  logic [ADDR_W-1:0] shifted;

  assign out_free  = !out_valid_q || res_o.ready;
  assign digit_ext = ADDR_W'(token_i.val);

  // multiply-by-radix as shifts, wraps at 32 bits
  always_comb begin
    case (part_radix)
      RX_HEX:  acc = (part_q << 4) + digit_ext;
      RX_OCT:  acc = (part_q << 3) + digit_ext;
      default: acc = (part_q << 3) + (part_q << 1) + digit_ext;
    endcase
  end

  always_comb begin
    case (parts_q)
      2'd0:    fits = 1'b1;
      2'd1:    fits = (part_q[ADDR_W-1:24] == '0);
      2'd2:    fits = (part_q[ADDR_W-1:16] == '0);
      default: fits = (part_q[ADDR_W-1:8] == '0);
    endcase
  end

  always_comb begin
    case (parts_q)
      2'd0:    shifted = part_q << 24;
      2'd1:    shifted = part_q << 16;
      default: shifted = part_q << 8;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    part_d     = part_q;
    prefix_d   = prefix_q;
    parts_d    = parts_q;
    emit       = 1'b0;
    ok_d       = 1'b0;
    addr_d     = '0;
    do_part    = 1'b0;
    part_radix = radix_q;

    case (phase_q)
      PH_START: begin
        if (token_i.cls != CC_DIGIT) begin
          emit = 1'b1;
        end else if (token_i.val == 4'd0) begin
          part_d  = '0;
          phase_d = PH_ZERO;
        end else begin
          radix_d = RX_DEC;
          part_d  = digit_ext;
          phase_d = PH_DIGIT;
        end
      end
      PH_ZERO: begin
        phase_d = PH_DIGIT;
        if (token_i.cls == CC_X) begin
          radix_d = RX_HEX;
        end else begin
          radix_d    = RX_OCT;
          part_radix = RX_OCT;
          do_part    = 1'b1;
        end
      end
      PH_DIGIT: begin
        do_part = 1'b1;
      end
      default: begin
        if (token_i.cls == CC_NUL) begin
          phase_d = PH_START;
        end
      end
    endcase

    if (do_part) begin
      if (token_i.cls == CC_DIGIT ||
          (part_radix == RX_HEX && token_i.cls == CC_HEXL)) begin
        part_d = acc;
      end else if (token_i.cls == CC_DOT) begin
        if (parts_q == 2'd3) begin
          emit = 1'b1;
        end else begin
          prefix_d = prefix_q | shifted;
          parts_d  = parts_q + 2'd1;
          part_d   = '0;
          radix_d  = RX_DEC;
          phase_d  = PH_START;
        end
      end else begin
        emit = 1'b1;
        if ((token_i.cls == CC_NUL || token_i.cls == CC_SPACE) && fits) begin
          ok_d   = 1'b1;
          addr_d = part_q | prefix_q;
        end
      end
    end

    if (emit) begin
      phase_d  = (token_i.cls == CC_NUL) ? PH_START : PH_WAIT;
      radix_d  = RX_DEC;
      part_d   = '0;
      prefix_d = '0;
      parts_d  = '0;
    end
  end

  // a token that yields a result waits for the output register
  assign pop_o = !empty_i && (!emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      radix_q     <= RX_DEC;
      part_q      <= '0;
      prefix_q    <= '0;
      parts_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      addr_q      <= '0;
    end else begin
      if (pop_o) begin
        phase_q  <= phase_d;
        radix_q  <= radix_d;
        part_q   <= part_d;
        prefix_q <= prefix_d;
        parts_q  <= parts_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
        ok_q        <= ok_d;
        addr_q      <= addr_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.ok      = ok_q;
  assign res_o.address = addr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit) |-> out_free)
    else $error("result overwrote a pending request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START) |-> (part_q == '0 && radix_q == RX_DEC))
    else $error("part not cleared at start of part");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (prefix_q == '0 && parts_q == 2'd0 && part_q == '0))
    else $error("state not cleared while waiting for NUL");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(addr_q) && $stable(ok_q)))
    else $error("stalled result changed");

endmodule

>>> rtl/core/ipv4_dotted_address_parser_core.sv
// Top level of the dotted IPv4 address parser: classifier, token queue, parser.
// Depends on ipv4p_pkg, ipv4p_char_if, ipv4p_res_if, ipv4p_front, ipv4p_queue, ipv4p_back.
//
//   port    dir   payload                    items
//   char_i  in    char_in[7:0]               one ASCII character per request
//   res_o   out   ok, address[31:0]          zero or one per character
//
// One character per cycle sustained while res_o accepts results; the parser back end is the only loop.
// A result enters the output register when its terminating character leaves the token queue.
// Reset clears the queue, the parser state and the output register.
// A pending result held by res_o stalls only terminating characters; the
// two-entry queue absorbs the rest, and a full queue drops char_i.ready.
module ipv4_dotted_address_parser_core import ipv4p_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4p_char_if.sink    char_i,
  ipv4p_res_if.source   res_o
);

  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  token_t push_token;
  token_t pop_token;

  ipv4p_front u_front (
    .char_i  (char_i),
    .full_i  (full),
    .push_o  (push),
    .token_o (push_token)
  );

  ipv4p_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_token),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_token),
    .empty_o     (empty)
  );

  ipv4p_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .token_i (pop_token),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ipv4_dotted_address_parser_core: streams character
// requests and checks each result request against a behavioral predictor.
// Depends on ipv4p_pkg, ipv4p_char_if, ipv4p_res_if and the parser RTL.
module tb import ipv4p_pkg::*; ();

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] address;
  } addr_result_t;

  class address_scoreboard;
    typedef enum logic [1:0] {ST_FIRST, ST_LEAD_ZERO, ST_IN_PART, ST_SKIP} parse_st_e;
    typedef enum logic [1:0] {RDX_DEC, RDX_OCT, RDX_HEX} radix_e;

    parse_st_e    st;
    radix_e       rdx;
    logic [31:0]  part_val;
    logic [31:0]  prefix;
    logic [1:0]   n_dots;
    addr_result_t expected_addrs[$];
    int           errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      st       = ST_FIRST;
      rdx      = RDX_DEC;
      part_val = '0;
      prefix   = '0;
      n_dots   = '0;
    endfunction

    function bit is_dig(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= CH_LA && c <= CH_LF) return int'(c) - 87;
      if (c >= CH_UA && c <= CH_UF) return int'(c) - 55;
      return -1;
    endfunction

    function void emit(logic [7:0] c, logic ok, logic [31:0] addr);
      addr_result_t r;
      r.ok      = ok;
      r.address = ok ? addr : 32'h0;
      expected_addrs.push_back(r);
      clear();
      // anything but NUL leaves the rest of the string to be skipped
      st = (c == CH_NUL) ? ST_FIRST : ST_SKIP;
    endfunction

    function void terminate(logic [7:0] c);
      logic [31:0] lim;
      if (c != CH_NUL && !is_ws(c)) begin
        emit(c, 1'b0, '0);
        return;
      end
      case (n_dots)
        2'd0:    lim = 32'hffff_ffff;
        2'd1:    lim = 32'h00ff_ffff;
        2'd2:    lim = 32'h0000_ffff;
        default: lim = 32'h0000_00ff;
      endcase
      if (part_val > lim) emit(c, 1'b0, '0);
      else emit(c, 1'b1, part_val | prefix);
    endfunction

    function void part_char(logic [7:0] c);
      int          h;
      logic [31:0] m;
      h = hex_val(c);
      if (is_dig(c)) begin
        m = (rdx == RDX_HEX) ? 32'd16 : (rdx == RDX_OCT) ? 32'd8 : 32'd10;
        part_val = part_val * m + 32'(c - CH_0);
      end else if (rdx == RDX_HEX && h >= 0) begin
        part_val = (part_val << 4) | 32'(h);
      end else if (c == CH_DOT) begin
        if (n_dots == 2'd3) begin
          emit(c, 1'b0, '0);
        end else begin
          prefix   = prefix | (part_val << (24 - 8 * int'(n_dots)));
          n_dots   = n_dots + 2'd1;
          part_val = '0;
          rdx      = RDX_DEC;
          st       = ST_FIRST;
        end
      end else begin
        terminate(c);
      end
    endfunction

    // Returns 1 when the character was not simply skipped.
    function bit predict_char(logic [7:0] c);
      bit live;
      live = (st != ST_SKIP);
      case (st)
        ST_FIRST: begin
          if (!is_dig(c)) begin
            emit(c, 1'b0, '0);
          end else begin
            part_val = '0;
            if (c == CH_0) begin
              st = ST_LEAD_ZERO;
            end else begin
              rdx      = RDX_DEC;
              part_val = 32'(c - CH_0);
              st       = ST_IN_PART;
            end
          end
        end
        ST_LEAD_ZERO: begin
          st = ST_IN_PART;
          if (c == CH_LX || c == CH_UX) begin
            rdx = RDX_HEX;
          end else begin
            rdx = RDX_OCT;
            part_char(c);
          end
        end
        ST_IN_PART: part_char(c);
        default: if (c == CH_NUL) clear();
      endcase
      return live;
    endfunction

    function void compare_address(logic ok, logic [31:0] addr);
      addr_result_t e;
      if (expected_addrs.size() == 0) begin
        $display("%0t: unexpected result: expected none, got ok=%0b address=%h",
                 $time, ok, addr);
        errors++;
        return;
      end
      e = expected_addrs.pop_front();
      if (ok !== e.ok) begin
        $display("%0t: ok mismatch: expected %0b, got %0b", $time, e.ok, ok);
        errors++;
      end
      if (addr !== e.address) begin
        $display("%0t: address mismatch: expected %h, got %h", $time, e.address, addr);
        errors++;
      end
    endfunction

    function int pending();
      return expected_addrs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   snd_idle;
  int   rcv_idle;
  int   counted;

  address_scoreboard sb = new();

  ipv4p_char_if char_bus ();
  ipv4p_res_if  res_bus ();

  ipv4_dotted_address_parser_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .res_o  (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side backpressure
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_bus.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // sample at negedge: the values there hold through the next rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready)
        sb.compare_address(res_bus.ok, res_bus.address);
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < snd_idle) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid   <= 1'b1;
    char_bus.char_in <= c;
    @(negedge clk_i);
    while (!char_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    void'(sb.predict_char(c));
    counted++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic wait_results_drained();
    char_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void add_text(ref logic [7:0] s[$], input string t,
                                   input logic [7:0] tail);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    s.push_back(tail);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'(CH_0 + n);
    return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + n - 4'd10);
  endfunction

  // One part in a random notation; the last case is a raw digit run that
  // exercises 8/9 in octal and 32-bit wrap.
  function automatic void add_part(ref logic [7:0] s[$], input logic [31:0] v);
    logic [7:0]  d[$];
    logic [31:0] x;
    x = v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        do begin
          d.push_front(8'(CH_0 + x % 10));
          x = x / 10;
        end while (x != 0);
      end
      4, 5: begin
        d.push_back(CH_0);
        while (x != 0) begin
          d.insert(1, 8'(CH_0 + x % 8));
          x = x / 8;
        end
      end
      6: begin
        d.push_back(CH_0);
        d.push_back($urandom_range(0, 1) ? CH_UX : CH_LX);
        while (x != 0) begin
          d.insert(2, hex_char(x[3:0]));
          x = x >> 4;
        end
      end
      default: begin
        repeat ($urandom_range(1, 12)) d.push_back(8'(CH_0 + $urandom_range(0, 9)));
      end
    endcase
    foreach (d[i]) s.push_back(d[i]);
  endfunction

  function automatic void gen_address(ref logic [7:0] s[$]);
    int          nparts;
    int          roll;
    int          fault;
    int          bits;
    int          k;
    logic [31:0] v;
    s.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
      s.push_back(CH_NUL);
      return;
    end
    nparts = $urandom_range(1, 4);
    fault  = (roll < 28) ? $urandom_range(1, 5) : 0;
    for (int i = 0; i < nparts; i++) begin
      if (i > 0) s.push_back(CH_DOT);
      bits = (i == nparts - 1) ? 32 - 8 * (nparts - 1) : 8;
      v = $urandom;
      case ($urandom_range(0, 3))
        0: v = v & 32'hff;
        1: v = v & 32'hf;
        default: ;
      endcase
      // mostly in range; now and then let the part overflow its field
      if ($urandom_range(0, 19) != 0) v = v & (32'hffff_ffff >> (32 - bits));
      add_part(s, v);
    end
    case (fault)
      1: begin
        s.push_back(CH_DOT);
        if ($urandom_range(0, 1)) add_part(s, 32'($urandom_range(0, 255)));
      end
      2: s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
      3: s.insert($urandom_range(0, s.size()), 8'($urandom_range(33, 126)));
      4: s.push_back(8'($urandom_range(33, 126)));
      5: s.insert($urandom_range(0, s.size()), CH_DOT);
      default: ;
    endcase
    if ($urandom_range(0, 9) >= 6) begin
      k = $urandom_range(0, 5);
      s.push_back((k == 5) ? CH_SPACE : 8'(CH_TAB + k));
      repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(1, 255)));
    end
    s.push_back(CH_NUL);
  endfunction

  task automatic run_random(input int target);
    logic [7:0] s[$];
    int         start;
    start = counted;
    while (counted - start < target) begin
      gen_address(s);
      send_string(s);
    end
  endtask

  initial begin
    logic [7:0] s[$];
    char_bus.valid   <= 1'b0;
    char_bus.char_in <= '0;
    rst_ni           <= 1'b0;
    snd_idle = 18;
    rcv_idle = 52;
    counted  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, all notations with bare hex prefix, fifth part,
    // whitespace end, bad trailer, high byte
    add_text(s, "", CH_NUL);
    add_text(s, "0x.0XaF.09.255", CH_NUL);
    add_text(s, "1.2.3.4.", CH_NUL);
    add_text(s, "0x", CH_TAB);
    s.push_back(CH_NUL);
    add_text(s, "9z", CH_NUL);
    s.push_back(8'hff);
    s.push_back(CH_NUL);
    send_string(s);

    run_random(600);
    wait_results_drained();
    @(negedge clk_i);
    snd_idle = 52;
    rcv_idle = 18;
    @(posedge clk_i);
    run_random(575);
    wait_results_drained();
    @(negedge clk_i);
    snd_idle = 0;
    rcv_idle = 0;
    @(posedge clk_i);
    run_random(575);
    wait_results_drained();
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ipv4p_pkg.sv
rtl/core/ipv4p_char_if.sv
rtl/core/ipv4p_res_if.sv
rtl/core/ipv4p_queue.sv
rtl/core/ipv4p_front.sv
rtl/core/ipv4p_back.sv
rtl/core/ipv4_dotted_address_parser_core.sv
tb/sv/tb.sv
